// ===== design/assert_macros.svh =====
// Assertion macros shared by the sorted value table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SVT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted value table: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted value table: assertion failed");

// Invariant that holds at every edge outside reset.
`define SVT_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sorted value table: assertion failed");

`endif

// ===== design/svt_pkg.sv =====
// Shared constants and types of the sorted value table.
`default_nettype none

package svt_pkg;

   // Default table depth
   localparam int unsigned CAPACITY = 16;

   // Field widths
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned STATUS_W = 2;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the request beat
      logic compare;  // register the per-cell compare flags
      logic apply;    // update cells and count, load the response
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/sorted_value_table.sv =====
// Top level of the sorted value table: controller plus datapath.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order.
// Request channel (req_*): one beat is one operation; req_tuser carries the
// kind (insert, remove first equal value, clear) and req_tdata the value.
// Response channel (rsp_*): exactly one beat per request, carrying the new
// entry count (low 5 bits of the occupancy) and a status: done, insert
// dropped because the table is full, or remove found no match.
// Sequencing: a request is taken only while the controller is idle. It then
// runs the per-cell compare and then the shift, and the apply step loads the
// response register; a new request is taken only once the controller is back
// in idle, so one operation is handled at a time, in the capture / compare /
// apply sequence of the controller.
// A stalled response register does not block capture and compare of the
// next request; the apply step waits until the register is free, so no
// result is lost or overwritten.
// Reset empties the table at once (count to zero, no response pending);
// no clearing pass is needed.
`default_nettype none

module sorted_value_table #(
   parameter int unsigned CAPACITY = svt_pkg::CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [svt_pkg::VALUE_W-1:0]       req_tdata,   // [31:0] value
   input  wire logic [svt_pkg::KIND_W-1:0]        req_tuser,   // [1:0] kind
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [7:0]                             rsp_tdata    // [4:0] entry_count,
                                                               // [6:5] status, [7] zero
);

   svt_pkg::cmd_type                cmd;
   logic [svt_pkg::COUNT_W-1:0]     rsp_count;
   logic [svt_pkg::STATUS_W-1:0]    rsp_status;

   svt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   svt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_kind   (req_tuser),
      .req_value  (req_tdata),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

   // Pack the response beat, pad to a whole byte
   assign rsp_tdata = {1'b0, rsp_status, rsp_count};

endmodule

`default_nettype wire

// ===== design/svt_ctrl.sv =====
// Controller state machine of the sorted value table.
`default_nettype none
`include "assert_macros.svh"

module svt_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output svt_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_APPLY   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Response register can take a new beat when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Sequence one operation: capture, compare, apply
   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.compare = 1'b0;
      cmd.apply   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_APPLY;
         end
         ST_APPLY: begin
            if (slot_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Set valid on a new result, drop it once taken
   always_comb begin
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `SVT_ASSERT_NEXT(a_accept_to_compare, clock, reset, req_tvalid && req_tready,
                    state_ff == ST_COMPARE)
   `SVT_ASSERT_NEXT(a_apply_gives_result, clock, reset, cmd.apply, rsp_tvalid)
   `SVT_ASSERT_IMPL(a_apply_needs_slot, clock, reset, cmd.apply, slot_free)

endmodule

`default_nettype wire

// ===== design/svt_datapath.sv =====
// Cell array, occupancy count and response register of the sorted value table.
`default_nettype none
`include "assert_macros.svh"

module svt_datapath #(
   parameter  int unsigned CAPACITY = svt_pkg::CAPACITY,
   localparam int unsigned CW       = $clog2(CAPACITY + 1)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire svt_pkg::cmd_type                      cmd,
   input  wire logic        [svt_pkg::KIND_W-1:0]     req_kind,
   input  wire logic signed [svt_pkg::VALUE_W-1:0]    req_value,
   output logic             [svt_pkg::COUNT_W-1:0]    rsp_count,
   output logic             [svt_pkg::STATUS_W-1:0]   rsp_status
);

   logic        [svt_pkg::KIND_W-1:0]   kind_ff;
   logic signed [svt_pkg::VALUE_W-1:0]  value_ff;
   logic signed [svt_pkg::VALUE_W-1:0]  cell_ff [CAPACITY];
   logic signed [svt_pkg::VALUE_W-1:0]  cell_in [CAPACITY];
   logic        [CAPACITY-1:0]          le_ff, le_in;
   logic        [CAPACITY-1:0]          lt_ff, lt_in;
   logic        [CAPACITY-1:0]          first_ff, first_in;
   logic        [CW-1:0]                count_ff, count_in;
   logic        [svt_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic        [svt_pkg::STATUS_W-1:0] rsp_status_ff, status_in;
   logic                                full, found, do_insert, do_remove;

   assign full      = (count_ff >= CW'(CAPACITY));
   assign found     = |first_ff;
   assign do_insert = cmd.apply && (kind_ff == svt_pkg::KIND_INSERT) && !full;
   assign do_remove = cmd.apply && (kind_ff == svt_pkg::KIND_REMOVE) && found;

   // Per-cell compare and shift
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                               occupied, match;
      logic signed [svt_pkg::VALUE_W-1:0] ins_val, rem_val;

      assign occupied = (CW'(i) < count_ff);
      assign le_in[i] = occupied && (cell_ff[i] <= value_ff);
      assign lt_in[i] = occupied && (cell_ff[i] <  value_ff);
      assign match    = occupied && (cell_ff[i] == value_ff);

      // Insert: keep cells at or below the value, place it at the boundary, shift up above
      if (i == 0) begin : g_first
         assign first_in[i] = match;
         assign ins_val     = le_ff[i] ? cell_ff[i] : value_ff;
      end else begin : g_rest
         assign first_in[i] = match && lt_in[i-1];
         assign ins_val     = le_ff[i]   ? cell_ff[i] :
                              le_ff[i-1] ? value_ff   : cell_ff[i-1];
      end

      // Remove: keep cells below the value, shift down from the first match on
      if (i == CAPACITY - 1) begin : g_top
         assign rem_val = cell_ff[i];
      end else begin : g_low
         assign rem_val = lt_ff[i] ? cell_ff[i] : cell_ff[i+1];
      end

      assign cell_in[i] = do_insert ? ins_val :
                          do_remove ? rem_val : cell_ff[i];
   end

   // Next count and status of the applied operation
   always_comb begin
      count_in  = count_ff;
      status_in = svt_pkg::STATUS_DONE;
      unique case (kind_ff)
         svt_pkg::KIND_INSERT: begin
            if (full) begin
               status_in = svt_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         svt_pkg::KIND_REMOVE: begin
            if (found) begin
               count_in = count_ff - CW'(1);
            end else begin
               status_in = svt_pkg::STATUS_NOMATCH;
            end
         end
         svt_pkg::KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control state: count and compare flags
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         le_ff    <= '0;
         lt_ff    <= '0;
         first_ff <= '0;
      end else begin
         if (cmd.apply) begin
            count_ff <= count_in;
         end
         if (cmd.compare) begin
            le_ff    <= le_in;
            lt_ff    <= lt_in;
            first_ff <= first_in;
         end
      end
   end

   // Payload: captured request, cells, response
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      if (cmd.apply) begin
         rsp_count_ff  <= svt_pkg::COUNT_W'(count_in);
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   `SVT_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CW'(CAPACITY))
   `SVT_ASSERT_ALWAYS(a_single_first_match, clock, reset, $onehot0(first_ff))

endmodule

`default_nettype wire
